FILE: rtl/hwmb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hwmb_pkg
// Shared types and constants for the high-water-mark barrier.
// ----------------------------------------------------------------------------
package hwmb_pkg;

   localparam int MAX_PRODUCERS = 16;
   localparam int SLOT_W  = (MAX_PRODUCERS > 1) ? $clog2(MAX_PRODUCERS) : 1;
   localparam int CNT_W   = $clog2(MAX_PRODUCERS + 1);

   localparam int HWM_W    = 16;
   localparam int PCOUNT_W = 5;
   localparam int ID_W     = 5;
   localparam int TALLY_W  = 5;
   localparam int TOTAL_W  = 32;
   localparam int OUT_SLOT_W = 4;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_HWM    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PCOUNT = 1'b1;

   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = 1;
   localparam int CMD_CNT_W = 2;

   typedef enum logic [1:0] {
      OP_ISSUE = 2'd0,
      OP_TEST  = 2'd1,
      OP_DONE  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]      operation;
      logic [ID_W-1:0] producer_id;
   } req_type;

   typedef struct packed {
      logic                  released;
      logic [OUT_SLOT_W-1:0] producer_slot;
      logic [TOTAL_W-1:0]    release_total;
      logic                  last;
   } rsp_type;

   // Decoded command handed from the front to the back.
   typedef struct packed {
      op_type            op;
      logic              slot_ok;
      logic [SLOT_W-1:0] slot;
   } cmd_type;

endpackage
`default_nettype wire

FILE: rtl/hwmb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hwmb_front
// Accepts request items and decodes them into commands for the queue.
// ----------------------------------------------------------------------------
module hwmb_front (
   input  wire                     req_valid,
   output logic                    req_ready,
   input  hwmb_pkg::req_type       req_data,
   output logic                    cmd_push,
   output hwmb_pkg::cmd_type       cmd_data,
   input  wire                     cmd_ready
);
   import hwmb_pkg::*;

   assign req_ready = cmd_ready;
   assign cmd_push  = req_valid && cmd_ready;

   always_comb begin
      cmd_data.op      = op_type'(req_data.operation);
      // Ids are numbered from one; zero and ids past the last slot are flagged as having no valid slot.
      cmd_data.slot_ok = (req_data.producer_id != '0) &&
                         (int'(req_data.producer_id) <= MAX_PRODUCERS);
      cmd_data.slot    = SLOT_W'(req_data.producer_id - ID_W'(1));
   end

endmodule
`default_nettype wire

FILE: rtl/hwmb_cmd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hwmb_cmd_fifo
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module hwmb_cmd_fifo (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     in_push,
   input  hwmb_pkg::cmd_type       in_data,
   output logic                    in_ready,
   output logic                    out_valid,
   output hwmb_pkg::cmd_type       out_data,
   input  wire                     out_pop
);
   import hwmb_pkg::*;

   cmd_type                mem_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign in_ready  = (int'(count_ff) != CMD_DEPTH);
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign do_push   = in_push && in_ready;
   assign do_pop    = out_pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == CMD_DEPTH - 1) ? '0 : wr_ptr_ff + CMD_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == CMD_DEPTH - 1) ? '0 : rd_ptr_ff + CMD_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CMD_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CMD_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= CMD_DEPTH)
      else $error("command queue count past its depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty command queue with unequal pointers");

endmodule
`default_nettype wire

FILE: rtl/hwmb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hwmb_back
// Executes barrier commands, holds the barrier state and drives results.
// ----------------------------------------------------------------------------
module hwmb_back (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              cmd_valid,
   input  hwmb_pkg::cmd_type                cmd_data,
   output logic                             cmd_pop,
   input  wire [hwmb_pkg::HWM_W-1:0]        hwm,
   input  wire [hwmb_pkg::PCOUNT_W-1:0]     pcount,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output hwmb_pkg::rsp_type                rsp_data
);
   import hwmb_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type            state_ff, state_in;
   logic [HWM_W-1:0]     counts_ff [MAX_PRODUCERS];
   logic [HWM_W-1:0]     counts_in [MAX_PRODUCERS];
   logic [TALLY_W-1:0]   tally_ff, tally_in;
   logic [CNT_W-1:0]     active_ff, active_in;
   logic [TOTAL_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [SLOT_W-1:0]    idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]     limit;
   logic                 out_free;
   logic [HWM_W-1:0]     cur_count;
   logic [HWM_W-1:0]     next_count;
   logic                 emit_last;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign limit = (int'(pcount) > MAX_PRODUCERS) ? CNT_W'(MAX_PRODUCERS) : CNT_W'(pcount);
   assign cur_count  = counts_ff[cmd_data.slot];
   assign next_count = cur_count + HWM_W'(1);
   assign emit_last  = ((CNT_W'(idx_ff) + CNT_W'(1)) == n_ff);

   always_comb begin
      state_in     = state_ff;
      counts_in    = counts_ff;
      tally_in     = tally_ff;
      active_in    = active_ff;
      sum_in       = sum_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      cmd_pop      = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd_data.op)
                  OP_ISSUE: begin
                     cmd_pop = 1'b1;
                     if (cmd_data.slot_ok && (cur_count != '1)) begin
                        counts_in[cmd_data.slot] = next_count;
                        // Only a count that moves onto the mark raises the tally.
                        if ((next_count == hwm) && (tally_ff != '1)) begin
                           tally_in = tally_ff + TALLY_W'(1);
                        end
                     end
                  end
                  OP_TEST: begin
                     if (out_free) begin
                        cmd_pop = 1'b1;
                        if ({{CNT_W{1'b0}}, tally_ff} >= {{TALLY_W{1'b0}}, active_ff}) begin
                           sum_in   = sum_ff + TOTAL_W'(hwm);
                           tally_in = '0;
                           for (int i = 0; i < MAX_PRODUCERS; i++) begin
                              if (CNT_W'(i) < limit) begin
                                 counts_in[i] = '0;
                              end
                           end
                           n_in   = limit;
                           idx_in = '0;
                           if (limit != '0) begin
                              state_in = ST_EMIT;
                           end
                        end else begin
                           rsp_valid_in               = 1'b1;
                           rsp_data_in.released       = 1'b0;
                           rsp_data_in.producer_slot  = '0;
                           rsp_data_in.release_total  = sum_ff;
                           rsp_data_in.last           = 1'b1;
                        end
                     end
                  end
                  OP_DONE: begin
                     cmd_pop = 1'b1;
                     if (active_ff != '0) begin
                        active_in = active_ff - CNT_W'(1);
                     end
                  end
                  OP_CLEAR: begin
                     cmd_pop = 1'b1;
                     for (int i = 0; i < MAX_PRODUCERS; i++) begin
                        counts_in[i] = '0;
                     end
                     tally_in  = '0;
                     sum_in    = '0;
                     active_in = limit;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EMIT: begin
            // One continue message per producer slot, in slot order.
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.released      = 1'b1;
               rsp_data_in.producer_slot = OUT_SLOT_W'(idx_ff);
               rsp_data_in.release_total = sum_ff;
               rsp_data_in.last          = emit_last;
               idx_in                    = idx_ff + SLOT_W'(1);
               if (emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         for (int i = 0; i < MAX_PRODUCERS; i++) begin
            counts_ff[i] <= '0;
         end
         tally_ff     <= '0;
         active_ff    <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counts_ff    <= counts_in;
         tally_ff     <= tally_in;
         active_ff    <= active_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff        <= n_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_emit_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (CNT_W'(idx_ff) < n_ff))
      else $error("release walk index past the producer count");

   a_emit_no_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> !cmd_pop)
      else $error("command taken during a release walk");

   a_last_ends_walk: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT) && out_free && emit_last) |=> (state_ff == ST_IDLE))
      else $error("release walk did not end after its final item");

endmodule
`default_nettype wire

FILE: rtl/high_water_mark_barrier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// high_water_mark_barrier
// Barrier that releases a group of producers once each has issued the mark.
// ----------------------------------------------------------------------------
// Request items enter a two-entry command queue in the cycle they are
// accepted; the execution side retires issue, done and clear items at one
// item per cycle while no test ahead of them is waiting or sending continue
// messages. A test item waits for a free result register; one that is not
// released yields one result. A released test updates the state and then
// sends one continue message per registered producer (up to 16) through
// the result register, taking no new item until the last one is sent.
// Configuration registers take effect for items executed after the write.
module high_water_mark_barrier (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  hwmb_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output hwmb_pkg::rsp_type                    rsp_data,
   input  wire                                  csr_we,
   input  wire [hwmb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire [hwmb_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import hwmb_pkg::*;

   logic [HWM_W-1:0]    hwm_ff;
   logic [PCOUNT_W-1:0] pcount_ff;

   logic     front_push;
   cmd_type  front_cmd;
   logic     fifo_ready;
   logic     fifo_valid;
   cmd_type  fifo_cmd;
   logic     back_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         hwm_ff    <= HWM_W'(1);
         pcount_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HWM:    hwm_ff    <= HWM_W'(csr_wdata);
            CSR_PCOUNT: pcount_ff <= PCOUNT_W'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   hwmb_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_push  (front_push),
      .cmd_data  (front_cmd),
      .cmd_ready (fifo_ready)
   );

   hwmb_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_push   (front_push),
      .in_data   (front_cmd),
      .in_ready  (fifo_ready),
      .out_valid (fifo_valid),
      .out_data  (fifo_cmd),
      .out_pop   (back_pop)
   );

   hwmb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (fifo_valid),
      .cmd_data  (fifo_cmd),
      .cmd_pop   (back_pop),
      .hwm       (hwm_ff),
      .pcount    (pcount_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
